FILE: rtl/core/nau_pkg.sv
`timescale 1ns / 1ps

package nau_pkg;

  // Geometry of the feature transformer
  localparam int DIMS         = 256;
  localparam int PSQT_BUCKETS = 8;
  localparam int FEATURE_ROWS = 1024;

  // Datapath: LANES main lanes per beat, BEATS beats per feature row
  localparam int LANES    = 16;
  localparam int LANE_W   = $clog2(LANES);
  localparam int BEATS    = DIMS / LANES;
  localparam int BEAT_W   = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int ROWIDX_W = (FEATURE_ROWS > 1) ? $clog2(FEATURE_ROWS) : 1;
  localparam int BKT_W    = (PSQT_BUCKETS > 1) ? $clog2(PSQT_BUCKETS) : 1;
  localparam int WDEPTH   = FEATURE_ROWS * BEATS;
  localparam int WADDR_W  = $clog2(WDEPTH);
  localparam int AROWS    = 2 * BEATS;
  localparam int AADDR_W  = $clog2(AROWS);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 8;
  localparam int VAL_W    = 32;
  localparam int MW       = 16;
  localparam int BW       = 32;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OP_CLEAR     = opcode_t'(0);
  localparam opcode_t OP_ADD       = opcode_t'(1);
  localparam opcode_t OP_SUB       = opcode_t'(2);
  localparam opcode_t OP_WR_MAIN   = opcode_t'(3);
  localparam opcode_t OP_WR_BUCKET = opcode_t'(4);
  localparam opcode_t OP_RD_MAIN   = opcode_t'(5);
  localparam opcode_t OP_RD_BUCKET = opcode_t'(6);

  // Work kinds after classification; out-of-range items become CMD_NOP
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_ADD,
    CMD_SUB,
    CMD_WR_MAIN,
    CMD_WR_BKT,
    CMD_RD_MAIN,
    CMD_RD_BKT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               side;
    logic [ROWIDX_W-1:0] row;
    logic [BEAT_W-1:0]  beat;
    logic [LANE_W-1:0]  lane;
    logic [BKT_W-1:0]   bkt;
    logic [VAL_W-1:0]   wval;
  } cmd_t;

  typedef logic [LANES-1:0][MW-1:0]        lane_vec_t;
  typedef logic [PSQT_BUCKETS-1:0][BW-1:0] bkt_vec_t;

  // Word address of one beat of a weight row
  function automatic logic [WADDR_W-1:0] w_addr(input logic [ROWIDX_W-1:0] row,
                                                 input logic [BEAT_W-1:0] beat);
    return WADDR_W'(WADDR_W'(row) * WADDR_W'(BEATS) + WADDR_W'(beat));
  endfunction

  // Row address of one beat of a side's accumulator
  function automatic logic [AADDR_W-1:0] acc_addr(input logic side,
                                                   input logic [BEAT_W-1:0] beat);
    return AADDR_W'(AADDR_W'(side) * AADDR_W'(BEATS) + AADDR_W'(beat));
  endfunction

endpackage

FILE: rtl/core/nau_in_if.sv
`timescale 1ns / 1ps

interface nau_in_if;
  logic                           valid;
  logic                           ready;
  logic [nau_pkg::OPCODE_W-1:0]   opcode;
  logic                           side;
  logic [nau_pkg::ROW_W-1:0]      feature_row;
  logic [nau_pkg::COL_W-1:0]      column;
  logic signed [nau_pkg::VAL_W-1:0] write_value;

  modport source (output valid, output opcode, output side, output feature_row,
                  output column, output write_value, input ready);
  modport sink (input valid, input opcode, input side, input feature_row,
                input column, input write_value, output ready);
endinterface

FILE: rtl/core/nau_out_if.sv
`timescale 1ns / 1ps

interface nau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [nau_pkg::VAL_W-1:0] read_value;
  logic                             is_read;

  modport source (output valid, output read_value, output is_read, input ready);
  modport sink (input valid, input read_value, input is_read, output ready);
endinterface

FILE: rtl/core/nnue_accumulator_update.sv
`timescale 1ns / 1ps

// Feature-transformer accumulator engine with two accumulators, one per side.
// req carries one command item (opcode, side, feature_row, column, write_value);
// rsp returns exactly one item per command, in order (read_value, is_read).
// Items are taken on valid && ready on either channel.
// Commands land in a two-entry queue; the execution side works one at a time.
// Every result goes through the output register: clear, weight writes, bucket
// reads and ignored commands go there straight from the queue; a main read
// passes the accumulator row register first; a row add or subtract first runs
// its 16-lane read-modify-write pass over all BEATS beats of the weight row
// memory and the accumulator row memory, occupying the execution side.
// Throughput: one short command per cycle while rsp takes each result.
// Clear: per-row valid bits mark the main rows as zero; bucket sums are zeroed.
// Reset empties the queue, zeroes both accumulators and drops any pending
// result; weight memories are not cleared and must be written before use.
// When rsp stalls, the result holds in the output register, the execution side
// waits at its end of the next item, and req backs up once the queue fills.
module nnue_accumulator_update (
  input  logic       clk,
  input  logic       rst,
  nau_in_if.sink     req,
  nau_out_if.source  rsp
);

  nau_pkg::cmd_t push_cmd;
  nau_pkg::cmd_t pop_cmd;
  logic          push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  // Classify incoming items
  nau_front u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Decouple front and back
  nau_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_cmd),
    .empty (q_empty)
  );

  // Execute commands and return results
  nau_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_dout  (pop_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

FILE: rtl/core/nau_front.sv
`timescale 1ns / 1ps

module nau_front (
  nau_in_if.sink          req,
  input  logic            q_full,
  output logic            push,
  output nau_pkg::cmd_t   cmd
);

  logic row_ok;
  logic main_ok;
  logic bkt_ok;

  // Range checks on row and column
  assign row_ok  = (32'(req.feature_row) < 32'(nau_pkg::FEATURE_ROWS));
  assign main_ok = (32'(req.column) < 32'(nau_pkg::DIMS));
  assign bkt_ok  = (32'(req.column) < 32'(nau_pkg::PSQT_BUCKETS));

  // Classify the item; anything that does nothing becomes a no-op
  always_comb begin
    unique case (req.opcode)
      nau_pkg::OP_CLEAR:     cmd.kind = nau_pkg::CMD_CLEAR;
      nau_pkg::OP_ADD:       cmd.kind = row_ok ? nau_pkg::CMD_ADD : nau_pkg::CMD_NOP;
      nau_pkg::OP_SUB:       cmd.kind = row_ok ? nau_pkg::CMD_SUB : nau_pkg::CMD_NOP;
      nau_pkg::OP_WR_MAIN:   cmd.kind = (row_ok && main_ok) ? nau_pkg::CMD_WR_MAIN
                                                            : nau_pkg::CMD_NOP;
      nau_pkg::OP_WR_BUCKET: cmd.kind = (row_ok && bkt_ok) ? nau_pkg::CMD_WR_BKT
                                                           : nau_pkg::CMD_NOP;
      nau_pkg::OP_RD_MAIN:   cmd.kind = main_ok ? nau_pkg::CMD_RD_MAIN : nau_pkg::CMD_NOP;
      nau_pkg::OP_RD_BUCKET: cmd.kind = bkt_ok ? nau_pkg::CMD_RD_BKT : nau_pkg::CMD_NOP;
      default:               cmd.kind = nau_pkg::CMD_NOP;
    endcase
  end

  // Split the column into beat, lane and bucket index
  assign cmd.side = req.side;
  assign cmd.row  = nau_pkg::ROWIDX_W'(req.feature_row);
  assign cmd.beat = nau_pkg::BEAT_W'(req.column >> nau_pkg::LANE_W);
  assign cmd.lane = req.column[nau_pkg::LANE_W-1:0];
  assign cmd.bkt  = nau_pkg::BKT_W'(req.column);
  assign cmd.wval = req.write_value;

  // Accept whenever the queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

endmodule

FILE: rtl/core/nau_queue.sv
`timescale 1ns / 1ps

module nau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nau_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output nau_pkg::cmd_t dout,
  output logic          empty
);

  nau_pkg::cmd_t              slots [nau_pkg::QDEPTH];
  logic [nau_pkg::QPTR_W-1:0] wptr;
  logic [nau_pkg::QPTR_W-1:0] rptr;
  logic [nau_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign full    = (count == nau_pkg::QCNT_W'(nau_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == nau_pkg::QPTR_W'(nau_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == nau_pkg::QPTR_W'(nau_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/nau_back.sv
`timescale 1ns / 1ps

module nau_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  nau_pkg::cmd_t q_dout,
  output logic          q_pop,
  nau_out_if.source     rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [nau_pkg::BEAT_W-1:0]  wb_beat;
  nau_pkg::cmd_t               cur;

  // Weight stores and accumulator rows
  nau_pkg::lane_vec_t wmem [nau_pkg::WDEPTH];
  nau_pkg::bkt_vec_t  bmem [nau_pkg::FEATURE_ROWS];
  nau_pkg::lane_vec_t amem [nau_pkg::AROWS];
  logic [nau_pkg::AROWS-1:0] acc_vld;
  logic [nau_pkg::BW-1:0]    bacc [2][nau_pkg::PSQT_BUCKETS];

  // Registered read data
  nau_pkg::lane_vec_t wrow;
  nau_pkg::bkt_vec_t  brow;
  nau_pkg::lane_vec_t arow;
  logic               avld_q;

  // Port controls
  logic                        w_re;
  logic [nau_pkg::WADDR_W-1:0] w_raddr;
  logic [nau_pkg::WADDR_W-1:0] w_waddr;
  logic                        b_re;
  logic                        a_re;
  logic [nau_pkg::AADDR_W-1:0] a_raddr;
  logic                        a_we;
  logic [nau_pkg::AADDR_W-1:0] a_waddr;

  logic                        slot_free;
  logic                        needs_slot;
  logic                        last_beat;
  logic                        emit;
  logic [nau_pkg::VAL_W-1:0]   emit_value;
  logic                        emit_is_read;
  nau_pkg::lane_vec_t          acc_eff;
  nau_pkg::lane_vec_t          sum_row;
  logic [nau_pkg::MW-1:0]      rd_lane;

  logic                        out_valid;
  logic [nau_pkg::VAL_W-1:0]   out_value;
  logic                        out_is_read;

  assign slot_free  = !out_valid || rsp.ready;
  assign needs_slot = !(q_dout.kind == nau_pkg::CMD_ADD || q_dout.kind == nau_pkg::CMD_SUB ||
                        q_dout.kind == nau_pkg::CMD_RD_MAIN);
  assign q_pop      = (state == S_IDLE) && !q_empty && (slot_free || !needs_slot);
  assign last_beat  = (wb_beat == nau_pkg::BEAT_W'(nau_pkg::BEATS - 1));
  assign w_waddr    = nau_pkg::w_addr(q_dout.row, q_dout.beat);

  // Issue reads: row beat zero or a main read at pop, later beats during the row pass
  always_comb begin
    w_re    = 1'b0;
    b_re    = 1'b0;
    a_re    = 1'b0;
    w_raddr = nau_pkg::w_addr(cur.row, wb_beat + 1'b1);
    a_raddr = nau_pkg::acc_addr(cur.side, wb_beat + 1'b1);
    if (state == S_IDLE) begin
      if (q_pop && (q_dout.kind == nau_pkg::CMD_ADD || q_dout.kind == nau_pkg::CMD_SUB)) begin
        w_re    = 1'b1;
        b_re    = 1'b1;
        a_re    = 1'b1;
        w_raddr = nau_pkg::w_addr(q_dout.row, '0);
        a_raddr = nau_pkg::acc_addr(q_dout.side, '0);
      end else if (q_pop && q_dout.kind == nau_pkg::CMD_RD_MAIN) begin
        a_re    = 1'b1;
        a_raddr = nau_pkg::acc_addr(q_dout.side, q_dout.beat);
      end
    end else if (state == S_ROW && !last_beat) begin
      w_re = 1'b1;
      a_re = 1'b1;
    end
  end

  // Add or subtract one beat of the weight row; unwritten accumulator rows read as zero
  assign acc_eff = avld_q ? arow : '0;
  always_comb begin
    for (int l = 0; l < nau_pkg::LANES; l++) begin
      sum_row[l] = (cur.kind == nau_pkg::CMD_SUB) ? acc_eff[l] - wrow[l]
                                                  : acc_eff[l] + wrow[l];
    end
  end

  assign a_we    = (state == S_ROW);
  assign a_waddr = nau_pkg::acc_addr(cur.side, wb_beat);
  assign rd_lane = acc_eff[cur.lane];

  // Pick the result for the item that finishes this cycle
  always_comb begin
    emit         = 1'b0;
    emit_value   = '0;
    emit_is_read = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_pop && needs_slot) begin
          emit = 1'b1;
          if (q_dout.kind == nau_pkg::CMD_RD_BKT) begin
            emit_value   = bacc[q_dout.side][q_dout.bkt];
            emit_is_read = 1'b1;
          end
        end
      end
      S_ROW:  emit = last_beat && slot_free;
      S_RD: begin
        emit         = slot_free;
        emit_value   = {{(nau_pkg::VAL_W - nau_pkg::MW){rd_lane[nau_pkg::MW-1]}}, rd_lane};
        emit_is_read = 1'b1;
      end
      S_FIN:  emit = slot_free;
      default: emit = 1'b0;
    endcase
  end

  // Sequence the item
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop && (q_dout.kind == nau_pkg::CMD_ADD || q_dout.kind == nau_pkg::CMD_SUB)) begin
          state_next = S_ROW;
        end else if (q_pop && q_dout.kind == nau_pkg::CMD_RD_MAIN) begin
          state_next = S_RD;
        end
      end
      S_ROW: begin
        if (last_beat) begin
          state_next = slot_free ? S_IDLE : S_FIN;
        end
      end
      S_RD:  state_next = slot_free ? S_IDLE : S_RD;
      S_FIN: state_next = slot_free ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wb_beat <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        wb_beat <= '0;
      end else if (state == S_ROW && !last_beat) begin
        wb_beat <= wb_beat + 1'b1;
      end
    end
  end

  // Hold the popped command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_dout;
    end
  end

  // Main weight memory
  always_ff @(posedge clk) begin
    if (q_pop && q_dout.kind == nau_pkg::CMD_WR_MAIN) begin
      wmem[w_waddr][q_dout.lane] <= q_dout.wval[nau_pkg::MW-1:0];
    end
    if (w_re) begin
      wrow <= wmem[w_raddr];
    end
  end

  // Bucket weight memory
  always_ff @(posedge clk) begin
    if (q_pop && q_dout.kind == nau_pkg::CMD_WR_BKT) begin
      bmem[q_dout.row][q_dout.bkt] <= q_dout.wval;
    end
    if (b_re) begin
      brow <= bmem[q_dout.row];
    end
  end

  // Accumulator row memory
  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= sum_row;
    end
    if (a_re) begin
      arow   <= amem[a_raddr];
      avld_q <= acc_vld[a_raddr];
    end
  end

  // Row valid bits and bucket accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
      for (int s = 0; s < 2; s++) begin
        for (int b = 0; b < nau_pkg::PSQT_BUCKETS; b++) begin
          bacc[s][b] <= '0;
        end
      end
    end else begin
      if (q_pop && q_dout.kind == nau_pkg::CMD_CLEAR) begin
        for (int b = 0; b < nau_pkg::BEATS; b++) begin
          acc_vld[nau_pkg::acc_addr(q_dout.side, nau_pkg::BEAT_W'(b))] <= 1'b0;
        end
        for (int b = 0; b < nau_pkg::PSQT_BUCKETS; b++) begin
          bacc[q_dout.side][b] <= '0;
        end
      end
      if (a_we) begin
        acc_vld[a_waddr] <= 1'b1;
      end
      if (state == S_ROW && wb_beat == '0) begin
        for (int b = 0; b < nau_pkg::PSQT_BUCKETS; b++) begin
          bacc[cur.side][b] <= (cur.kind == nau_pkg::CMD_SUB) ? bacc[cur.side][b] - brow[b]
                                                               : bacc[cur.side][b] + brow[b];
        end
      end
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value   <= emit_value;
      out_is_read <= emit_is_read;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.is_read    = out_is_read;

endmodule

FILE: rtl/core/nau_checker.sv
`timescale 1ns / 1ps

module nau_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [nau_pkg::VAL_W-1:0]     read_value,
  input logic                          is_read
);

  localparam int MAX_INFLIGHT = nau_pkg::QDEPTH + 2;
  localparam int CNT_W        = $clog2(MAX_INFLIGHT + 2);

  logic [CNT_W-1:0] inflight;

  // Track items accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({req_valid && req_ready, rsp_valid && rsp_ready})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(is_read))
    else $error("stalled result changed");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_read |-> read_value == '0)
    else $error("non-read result carries data");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> inflight != '0)
    else $error("result without an accepted item");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(MAX_INFLIGHT))
    else $error("more items in flight than the block can hold");

endmodule

bind nnue_accumulator_update nau_checker u_nau_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_value (rsp.read_value),
  .is_read    (rsp.is_read)
);

FILE: test/nnue_accumulator_update_tb.sv
`timescale 1ns / 1ps

module nnue_accumulator_update_tb;

  localparam nau_pkg::opcode_t OP_NONE = nau_pkg::opcode_t'(7);

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 160;
  localparam int PAUSE_EVERY  = 70;
  localparam int STALL_AT     = 320;
  localparam int STALL_LEN    = 300;
  localparam int CALM_FROM    = 360;
  localparam int CALM_TO      = 430;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int FULL_ROW     = nau_pkg::FEATURE_ROWS - 1;

  typedef struct {
    nau_pkg::opcode_t           opcode;
    logic                       side;
    logic [nau_pkg::ROW_W-1:0]  row;
    logic [nau_pkg::COL_W-1:0]  col;
    logic [nau_pkg::VAL_W-1:0]  wval;
    bit                         pause;
  } upd_item_t;

  typedef struct {
    logic [nau_pkg::VAL_W-1:0] value;
    logic                      is_read;
  } upd_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nau_in_if  req ();
  nau_out_if rsp ();

  nnue_accumulator_update dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predictor state: accumulators per side and the weights written so far
  logic [nau_pkg::MW-1:0] acc_lanes   [2][nau_pkg::DIMS];
  logic [nau_pkg::BW-1:0] acc_buckets [2][nau_pkg::PSQT_BUCKETS];
  logic [nau_pkg::MW-1:0] weight_lanes   [int];
  logic [nau_pkg::BW-1:0] weight_buckets [int];

  upd_item_t   pending_items[$];
  upd_result_t expected_results[$];
  upd_item_t   cur_item;
  bit          item_taken;
  int          sent_cnt;
  int          mismatch_cnt;
  int          cycle_cnt;
  int          stall_left;
  bit          stall_done;
  logic        calm;

  assign calm = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);

  always #1 clk = ~clk;

  // Apply one accepted item to the predictor and queue its result
  function automatic void predict_result(input upd_item_t c);
    upd_result_t r;
    logic [nau_pkg::MW-1:0] w16;
    logic [nau_pkg::BW-1:0] w32;
    int base;
    r.value   = '0;
    r.is_read = 1'b0;
    case (c.opcode)
      nau_pkg::OP_CLEAR: begin
        for (int i = 0; i < nau_pkg::DIMS; i++) acc_lanes[c.side][i] = '0;
        for (int i = 0; i < nau_pkg::PSQT_BUCKETS; i++) acc_buckets[c.side][i] = '0;
      end
      nau_pkg::OP_ADD, nau_pkg::OP_SUB: begin
        if (int'(c.row) < nau_pkg::FEATURE_ROWS) begin
          base = int'(c.row) * nau_pkg::DIMS;
          for (int i = 0; i < nau_pkg::DIMS; i++) begin
            w16 = weight_lanes.exists(base + i) ? weight_lanes[base + i] : '0;
            acc_lanes[c.side][i] = (c.opcode == nau_pkg::OP_SUB)
                                   ? acc_lanes[c.side][i] - w16
                                   : acc_lanes[c.side][i] + w16;
          end
          base = int'(c.row) * nau_pkg::PSQT_BUCKETS;
          for (int i = 0; i < nau_pkg::PSQT_BUCKETS; i++) begin
            w32 = weight_buckets.exists(base + i) ? weight_buckets[base + i] : '0;
            acc_buckets[c.side][i] = (c.opcode == nau_pkg::OP_SUB)
                                     ? acc_buckets[c.side][i] - w32
                                     : acc_buckets[c.side][i] + w32;
          end
        end
      end
      nau_pkg::OP_WR_MAIN: begin
        if (int'(c.row) < nau_pkg::FEATURE_ROWS && int'(c.col) < nau_pkg::DIMS)
          weight_lanes[int'(c.row) * nau_pkg::DIMS + int'(c.col)] = c.wval[nau_pkg::MW-1:0];
      end
      nau_pkg::OP_WR_BUCKET: begin
        if (int'(c.row) < nau_pkg::FEATURE_ROWS && int'(c.col) < nau_pkg::PSQT_BUCKETS)
          weight_buckets[int'(c.row) * nau_pkg::PSQT_BUCKETS + int'(c.col)] = c.wval;
      end
      nau_pkg::OP_RD_MAIN: begin
        if (int'(c.col) < nau_pkg::DIMS) begin
          w16 = acc_lanes[c.side][c.col];
          r.value   = {{(nau_pkg::VAL_W - nau_pkg::MW){w16[nau_pkg::MW-1]}}, w16};
          r.is_read = 1'b1;
        end
      end
      nau_pkg::OP_RD_BUCKET: begin
        if (int'(c.col) < nau_pkg::PSQT_BUCKETS) begin
          r.value   = acc_buckets[c.side][c.col];
          r.is_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
    expected_results.push_back(r);
  endfunction

  task automatic push_item(input nau_pkg::opcode_t op, input logic side, input int row,
                           input int col, input logic [nau_pkg::VAL_W-1:0] val);
    upd_item_t c;
    c.opcode = op;
    c.side   = side;
    c.row    = nau_pkg::ROW_W'(row);
    c.col    = nau_pkg::COL_W'(col);
    c.wval   = val;
    c.pause  = 1'b0;
    pending_items.push_back(c);
  endtask

  // Marker: the sender holds off until every result has come back
  task automatic push_pause();
    upd_item_t c;
    c = '{opcode: OP_NONE, side: 1'b0, row: '0, col: '0, wval: '0, pause: 1'b1};
    pending_items.push_back(c);
  endtask

  // Record the accepted item
  always @(posedge clk) begin
    item_taken <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      predict_result(cur_item);
      sent_cnt <= sent_cnt + 1;
    end
  end

  // Offer the next item, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      req.valid       <= 1'b0;
      req.opcode      <= nau_pkg::OP_CLEAR;
      req.side        <= 1'b0;
      req.feature_row <= '0;
      req.column      <= '0;
      req.write_value <= '0;
    end else if (req.valid && !item_taken) begin
      // hold the offered item until it is taken
    end else begin
      if (pending_items.size() == 0) begin
        req.valid <= 1'b0;
      end else if (pending_items[0].pause) begin
        req.valid <= 1'b0;
        if (expected_results.size() == 0) void'(pending_items.pop_front());
      end else if (!calm && $urandom_range(99) < 20) begin
        req.valid <= 1'b0;
      end else begin
        cur_item        <= pending_items[0];
        req.opcode      <= pending_items[0].opcode;
        req.side        <= pending_items[0].side;
        req.feature_row <= pending_items[0].row;
        req.column      <= pending_items[0].col;
        req.write_value <= pending_items[0].wval;
        req.valid       <= 1'b1;
        void'(pending_items.pop_front());
      end
    end
  end

  // Drive result ready: random gaps plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && sent_cnt >= STALL_AT) begin
      rsp.ready  <= 1'b0;
      stall_done <= 1'b1;
      stall_left <= STALL_LEN;
    end else begin
      rsp.ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    upd_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: read_value %h is_read %b",
                   rsp.read_value, rsp.is_read);
        mismatch_cnt <= mismatch_cnt + 1;
      end else begin
        e = expected_results.pop_front();
        if (rsp.read_value !== e.value || rsp.is_read !== e.is_read) begin
          if (mismatch_cnt < 10)
            $display("result mismatch: read_value exp %h got %h, is_read exp %b got %b",
                     e.value, rsp.read_value, e.is_read, rsp.is_read);
          mismatch_cnt <= mismatch_cnt + 1;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [nau_pkg::VAL_W-1:0] v;
    int k;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < nau_pkg::DIMS; i++) acc_lanes[s][i] = '0;
      for (int i = 0; i < nau_pkg::PSQT_BUCKETS; i++) acc_buckets[s][i] = '0;
    end

    // Fill the top row completely so that it can be added
    for (int i = 0; i < nau_pkg::DIMS; i++) begin
      v = $urandom();
      case ($urandom_range(7))
        0: v[nau_pkg::MW-1:0] = 16'h7FFF;
        1: v[nau_pkg::MW-1:0] = 16'h8000;
        2: v[nau_pkg::MW-1:0] = 16'hFFFF;
        default: begin
        end
      endcase
      push_item(nau_pkg::OP_WR_MAIN, 1'($urandom_range(1)), FULL_ROW, i, v);
    end
    for (int i = 0; i < nau_pkg::PSQT_BUCKETS; i++) begin
      v = $urandom();
      case ($urandom_range(3))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        default: begin
        end
      endcase
      push_item(nau_pkg::OP_WR_BUCKET, 1'($urandom_range(1)), FULL_ROW, i, v);
    end

    // Directed: reads after reset, wraps, out-of-range columns, unused opcode, clear
    push_item(nau_pkg::OP_RD_MAIN,   1'b0, 0, 0, '0);
    push_item(nau_pkg::OP_RD_MAIN,   1'b1, 0, 255, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b0, 0, 0, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b1, 0, nau_pkg::PSQT_BUCKETS - 1, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b0, 0, nau_pkg::PSQT_BUCKETS, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b1, 0, 255, '0);
    push_item(nau_pkg::OP_ADD,       1'b0, FULL_ROW, 0, '0);
    push_item(nau_pkg::OP_SUB,       1'b1, FULL_ROW, 0, '0);
    push_item(nau_pkg::OP_ADD,       1'b0, FULL_ROW, 0, '0);
    push_item(nau_pkg::OP_ADD,       1'b0, FULL_ROW, 0, '0);
    push_item(nau_pkg::OP_RD_MAIN,   1'b0, 0, 0, '0);
    push_item(nau_pkg::OP_RD_MAIN,   1'b0, 0, 255, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b0, 0, nau_pkg::PSQT_BUCKETS - 1, '0);
    push_item(nau_pkg::OP_RD_MAIN,   1'b1, 0, 128, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b1, 0, 0, '0);
    push_item(nau_pkg::OP_WR_MAIN,   1'b0, FULL_ROW, 255, 32'hABCD_8000);
    push_item(nau_pkg::OP_WR_BUCKET, 1'b0, FULL_ROW, nau_pkg::PSQT_BUCKETS, 32'h7FFF_FFFF);
    push_item(nau_pkg::OP_WR_BUCKET, 1'b1, 0, 255, 32'h1234_5678);
    push_item(nau_pkg::OP_WR_BUCKET, 1'b0, FULL_ROW, nau_pkg::PSQT_BUCKETS - 1,
              32'h8000_0000);
    push_item(OP_NONE,               1'b1, FULL_ROW, 255, 32'hFFFF_FFFF);
    push_item(nau_pkg::OP_ADD,       1'b0, FULL_ROW, 0, '0);
    push_item(nau_pkg::OP_RD_MAIN,   1'b0, 0, 255, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b0, 0, nau_pkg::PSQT_BUCKETS - 1, '0);
    push_item(nau_pkg::OP_CLEAR,     1'b0, 0, 0, '0);
    push_item(nau_pkg::OP_RD_MAIN,   1'b0, 0, 0, '0);
    push_item(nau_pkg::OP_RD_BUCKET, 1'b0, 0, nau_pkg::PSQT_BUCKETS - 1, '0);
    push_pause();

    // Random mix; row adds only touch the fully written row
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = $urandom_range(99);
      if (k < 30) begin
        push_item((k < 17) ? nau_pkg::OP_ADD : nau_pkg::OP_SUB, 1'($urandom_range(1)),
                  FULL_ROW, $urandom_range(255), $urandom());
      end else if (k < 50) begin
        push_item(nau_pkg::OP_RD_MAIN, 1'($urandom_range(1)),
                  $urandom_range(nau_pkg::FEATURE_ROWS - 1),
                  $urandom_range(255), $urandom());
      end else if (k < 62) begin
        push_item(nau_pkg::OP_RD_BUCKET, 1'($urandom_range(1)),
                  $urandom_range(nau_pkg::FEATURE_ROWS - 1),
                  ($urandom_range(3) == 0) ? $urandom_range(255)
                                           : $urandom_range(nau_pkg::PSQT_BUCKETS - 1),
                  $urandom());
      end else if (k < 77) begin
        push_item(nau_pkg::OP_WR_MAIN, 1'($urandom_range(1)),
                  ($urandom_range(9) < 7) ? FULL_ROW
                                          : $urandom_range(nau_pkg::FEATURE_ROWS - 1),
                  $urandom_range(255), $urandom());
      end else if (k < 90) begin
        push_item(nau_pkg::OP_WR_BUCKET, 1'($urandom_range(1)),
                  ($urandom_range(9) < 7) ? FULL_ROW
                                          : $urandom_range(nau_pkg::FEATURE_ROWS - 1),
                  ($urandom_range(3) == 0) ? $urandom_range(255)
                                           : $urandom_range(nau_pkg::PSQT_BUCKETS - 1),
                  $urandom());
      end else if (k < 95) begin
        push_item(nau_pkg::OP_CLEAR, 1'($urandom_range(1)),
                  $urandom_range(nau_pkg::FEATURE_ROWS - 1),
                  $urandom_range(255), $urandom());
      end else begin
        push_item(OP_NONE, 1'($urandom_range(1)),
                  $urandom_range(nau_pkg::FEATURE_ROWS - 1),
                  $urandom_range(255), $urandom());
      end
      if (n % PAUSE_EVERY == PAUSE_EVERY - 1) push_pause();
    end

    // Release reset on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for all items to go in and all results to come back
    while (pending_items.size() != 0 || req.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/nau_pkg.sv
rtl/core/nau_in_if.sv
rtl/core/nau_out_if.sv
rtl/core/nau_front.sv
rtl/core/nau_queue.sv
rtl/core/nau_back.sv
rtl/core/nnue_accumulator_update.sv
rtl/core/nau_checker.sv
test/nnue_accumulator_update_tb.sv
